// ----- design/sfb_pkg.sv -----
// serial frame builder: shared types and constants
// used by sfb_seq, sfb_out and serial_frame_builder_core; no dependencies
`default_nettype none

package sfb_pkg;

  localparam logic [7:0] HEADER_BYTE = 8'hA5;
  localparam logic [7:0] FOOTER_0    = 8'hCC;
  localparam logic [7:0] FOOTER_1    = 8'h33;
  localparam logic [7:0] FOOTER_2    = 8'hC3;
  localparam logic [7:0] FOOTER_3    = 8'h3C;

  // which byte of the frame the sequencer emits next
  typedef enum logic [8:0] {
    STEP_HDR    = 9'b000000001,
    STEP_LEN_HI = 9'b000000010,
    STEP_LEN_LO = 9'b000000100,
    STEP_PAY    = 9'b000001000,
    STEP_FT0    = 9'b000010000,
    STEP_FT1    = 9'b000100000,
    STEP_FT2    = 9'b001000000,
    STEP_FT3    = 9'b010000000,
    STEP_PAR    = 9'b100000000
  } step_t;

  typedef struct packed {
    logic [7:0] data;
    logic       frame_done;
    logic       run_last;
  } result_t;

  typedef struct packed {
    logic busy;
    logic in_frame;
  } seq_stat_t;

endpackage : sfb_pkg

`default_nettype wire

// ----- design/sfb_seq.sv -----
// serial frame builder: item register and byte sequencer with running parity
// depends on sfb_pkg
`default_nettype none

module sfb_seq
  import sfb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_payload_byte,
  input  wire logic [15:0] in_frame_length,
  input  wire logic        in_last_payload,
  output logic             res_valid,
  input  wire logic        res_ready,
  output result_t          res,
  output seq_stat_t        stat
);

  logic        busy_r, busy_nxt;
  logic        in_frame_r, in_frame_nxt;
  logic [7:0]  parity_r, parity_nxt;
  step_t       step_r, step_nxt, step_adv;
  logic [7:0]  pb_r;
  logic [15:0] len_r;
  logic        last_r;
  logic        emit;
  logic        accept;
  logic        final_step;

  always_comb begin
    res.frame_done = 1'b0;
    res.run_last   = final_step;
    step_adv       = STEP_PAR;
    unique case (step_r)
      STEP_HDR: begin
        res.data = HEADER_BYTE;
        step_adv = STEP_LEN_HI;
      end
      STEP_LEN_HI: begin
        res.data = len_r[15:8];
        step_adv = STEP_LEN_LO;
      end
      STEP_LEN_LO: begin
        res.data = len_r[7:0];
        step_adv = STEP_PAY;
      end
      STEP_PAY: begin
        res.data = pb_r;
        step_adv = STEP_FT0;
      end
      STEP_FT0: begin
        res.data = FOOTER_0;
        step_adv = STEP_FT1;
      end
      STEP_FT1: begin
        res.data = FOOTER_1;
        step_adv = STEP_FT2;
      end
      STEP_FT2: begin
        res.data = FOOTER_2;
        step_adv = STEP_FT3;
      end
      STEP_FT3: begin
        res.data = FOOTER_3;
        step_adv = STEP_PAR;
      end
      STEP_PAR: begin
        res.data       = parity_r;
        res.frame_done = 1'b1;
      end
      default: begin
        res.data = parity_r;
      end
    endcase
  end

  assign final_step   = ((step_r == STEP_PAY) && !last_r) || (step_r == STEP_PAR);
  assign res_valid    = busy_r;
  assign emit         = busy_r && res_ready;
  assign in_ready     = !busy_r || (res_ready && final_step);
  assign accept       = in_valid && in_ready;

  always_comb begin
    in_frame_nxt = in_frame_r;
    parity_nxt   = parity_r;
    if (emit) begin
      if (step_r == STEP_PAR) begin
        in_frame_nxt = 1'b0;
        parity_nxt   = '0;
      end else begin
        parity_nxt = parity_r ^ res.data;
        if (step_r == STEP_HDR) begin
          in_frame_nxt = 1'b1;
        end
      end
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    if (accept) begin
      busy_nxt = 1'b1;
      step_nxt = in_frame_nxt ? STEP_PAY : STEP_HDR;
    end else if (emit) begin
      if (final_step) begin
        busy_nxt = 1'b0;
      end else begin
        step_nxt = step_adv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      in_frame_r <= 1'b0;
      parity_r   <= '0;
      step_r     <= STEP_HDR;
    end else begin
      busy_r     <= busy_nxt;
      in_frame_r <= in_frame_nxt;
      parity_r   <= parity_nxt;
      step_r     <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pb_r   <= in_payload_byte;
      len_r  <= in_frame_length;
      last_r <= in_last_payload;
    end
  end

  assign stat.busy     = busy_r;
  assign stat.in_frame = in_frame_r;

endmodule : sfb_seq

`default_nettype wire

// ----- design/sfb_out.sv -----
// serial frame builder: output register between sequencer and receiver
// depends on sfb_pkg
`default_nettype none

module sfb_out
  import sfb_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     res_valid,
  output logic          res_ready,
  input  wire result_t  res,
  output logic          out_valid,
  input  wire logic     out_ready,
  output result_t       out_res
);

  logic    valid_r, valid_nxt;
  result_t data_r;

  assign res_ready = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (res_ready) begin
      valid_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      data_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = data_r;

endmodule : sfb_out

`default_nettype wire

// ----- design/serial_frame_builder_core.sv -----
// serial frame builder top level: wraps payload beats into display command frames
// depends on sfb_pkg, sfb_seq and sfb_out
//
// input channel: in_valid/in_ready with one payload byte, the frame length and
// a last flag per beat. result channel: out_valid/out_ready with one frame byte
// per beat, frame_done on the closing parity byte and run_last on the final
// byte that an input beat causes.
// the first payload beat of a frame gives header, length high, length low and
// the payload byte; later beats give one byte; a last beat adds four footer
// bytes and the parity byte. while the receiver does not stall, the sequencer
// emits one frame byte per cycle; an input beat gives 1 byte in mid frame, 4
// when it opens a frame, 6 when it closes one and 9 for a one-byte frame; the
// next beat is taken in the same cycle as the final byte of the current one.
// an input beat reaches the output through the item register and the output register.
// reset clears the parity and the open-frame flag and empties both registers.
// when the receiver stalls, the output register holds and the sequencer and
// input channel stall behind it; nothing is dropped.
`default_nettype none

module serial_frame_builder_core
  import sfb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_payload_byte,
  input  wire logic [15:0] in_frame_length,
  input  wire logic        in_last_payload,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_byte,
  output logic             out_frame_done,
  output logic             out_run_last
);

  logic      res_valid;
  logic      res_ready;
  result_t   res;
  result_t   out_res;
  seq_stat_t stat;

  sfb_seq u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_payload_byte (in_payload_byte),
    .in_frame_length (in_frame_length),
    .in_last_payload (in_last_payload),
    .res_valid       (res_valid),
    .res_ready       (res_ready),
    .res             (res),
    .stat            (stat)
  );

  sfb_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_byte       = out_res.data;
  assign out_frame_done = out_res.frame_done;
  assign out_run_last   = out_res.run_last;

  a_done_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_done |-> out_run_last)
    else $error("frame_done beat without run_last");

  a_take_only_on_final: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && stat.busy |-> res_valid && res_ready && res.run_last)
    else $error("input beat taken while sequencer mid item");

  a_frame_closes_on_parity: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(stat.in_frame) |-> $past(res_valid && res_ready && res.frame_done))
    else $error("frame flag cleared without parity beat");

endmodule : serial_frame_builder_core

`default_nettype wire
